FILE: src/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk and held off during rst.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every edge outside reset.
`define PSR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Condition must never be true at an edge outside reset.
`define PSR_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

FILE: src/psr_pkg.sv
// ----------------------------------------------------------------------------
// psr_pkg
// Constants and types shared by the stereo polyphase resampler modules.
// ----------------------------------------------------------------------------
package psr_pkg;

  // Filter geometry
  localparam int HALF_TAPS  = 8;
  localparam int MAX_UP     = 16;
  localparam int TAPS       = 2 * HALF_TAPS + 1;
  localparam int BRANCH_LEN = HALF_TAPS + 1;
  localparam int COEF_DEPTH = (MAX_UP + 1) * BRANCH_LEN;

  // Field widths
  localparam int SAMPLE_W   = 24;
  localparam int COEF_W     = 18;
  localparam int OUT_W      = 16;
  localparam int IDX_W      = 8;
  localparam int UP_W       = 5;
  localparam int DOWN_W     = 12;
  localparam int PHASE_W    = 13;
  localparam int FRAC_BITS  = 17;

  // Derived widths
  localparam int COEF_AW    = $clog2(COEF_DEPTH);
  localparam int TAP_W      = $clog2(TAPS);
  localparam int BR_W       = $clog2(MAX_UP + 1);
  localparam int PROD_W     = SAMPLE_W + COEF_W;
  localparam int ACC_W      = PROD_W + $clog2(TAPS);

  // Configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = DOWN_W;
  localparam logic [CFG_IDX_W-1:0] REG_UP   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DOWN = 1'd1;

  // Input beat kinds
  localparam logic MODE_COEF   = 1'b0;
  localparam logic MODE_SAMPLE = 1'b1;

  // Sequencer states
  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_CHECK = 5'b00010,
    ST_RUN   = 5'b00100,
    ST_DRAIN = 5'b01000,
    ST_EMIT  = 5'b10000
  } psr_state_t;

  // Per-cycle lane control from the sequencer
  typedef struct packed {
    logic clear;
    logic mul_en;
    logic acc_en;
  } lane_ctrl_t;

endpackage

FILE: src/psr_ram.sv
// ----------------------------------------------------------------------------
// psr_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module psr_ram #(
  parameter int WIDTH = 18,
  parameter int DEPTH = 153
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: src/psr_lane.sv
// ----------------------------------------------------------------------------
// psr_lane
// One channel MAC lane: registered 24x18 product, then accumulate.
// ----------------------------------------------------------------------------
module psr_lane (
  input  logic                                clk,
  input  psr_pkg::lane_ctrl_t                 ctrl,
  input  logic signed [psr_pkg::COEF_W-1:0]   coef,
  input  logic signed [psr_pkg::SAMPLE_W-1:0] sample,
  output logic signed [psr_pkg::ACC_W-1:0]    acc
);
  import psr_pkg::*;

  logic signed [PROD_W-1:0] prod;

  // Multiply stage
  always_ff @(posedge clk) begin
    if (ctrl.mul_en) begin
      prod <= coef * sample;
    end
  end

  // Accumulate stage; clear starts a new output
  always_ff @(posedge clk) begin
    if (ctrl.clear) begin
      acc <= '0;
    end else if (ctrl.acc_en) begin
      acc <= acc + ACC_W'(prod);
    end
  end

endmodule

FILE: src/psr_merge.sv
// ----------------------------------------------------------------------------
// psr_merge
// Merges both lane sums into one output beat: round toward zero, saturate,
// and hold it in the output register until taken.
// ----------------------------------------------------------------------------
module psr_merge (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               load,
  input  logic signed [psr_pkg::ACC_W-1:0]   acc_l,
  input  logic signed [psr_pkg::ACC_W-1:0]   acc_r,
  input  logic                               last,
  output logic                               slot_free,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic signed [psr_pkg::OUT_W-1:0]   left_out,
  output logic signed [psr_pkg::OUT_W-1:0]   right_out,
  output logic                               last_in_run
);
  import psr_pkg::*;

  localparam int Q_W = ACC_W - FRAC_BITS;

  // Drop fraction toward zero, clamp to the output range
  function automatic logic signed [OUT_W-1:0] finish(input logic signed [ACC_W-1:0] a);
    logic signed [ACC_W-1:0] biased;
    logic signed [Q_W-1:0]   q;
    biased = a + (a[ACC_W-1] ? ACC_W'((1 << FRAC_BITS) - 1) : ACC_W'(0));
    q      = Q_W'(biased >>> FRAC_BITS);
    if (q > Q_W'((1 << (OUT_W - 1)) - 1)) begin
      finish = {1'b0, {(OUT_W-1){1'b1}}};
    end else if (q < -Q_W'(1 << (OUT_W - 1))) begin
      finish = {1'b1, {(OUT_W-1){1'b0}}};
    end else begin
      finish = OUT_W'(q);
    end
  endfunction

  assign slot_free = !out_valid || out_ready;

  // Output beat valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // Output payload
  always_ff @(posedge clk) begin
    if (load) begin
      left_out    <= finish(acc_l);
      right_out   <= finish(acc_r);
      last_in_run <= last;
    end
  end

endmodule

FILE: src/polyphase_stereo_resampler.sv
// ----------------------------------------------------------------------------
// polyphase_stereo_resampler
// Rational-ratio polyphase FIR resampler, stereo, two MAC lanes sharing one
// coefficient RAM read per cycle.
//
//   channel | signals                                        | direction
//   --------+------------------------------------------------+----------
//   cfg     | cfg_valid cfg_ready cfg_index cfg_data         | in
//   in      | in_valid in_ready mode coef_index coef_value   | in
//           | left_in right_in                               |
//   out     | out_valid out_ready left_out right_out         | out
//           | last_in_run                                    |
//
// A coefficient beat is a single RAM write. A sample beat gives n outputs
// (1..up_factor) or none: per output a check, 17 tap reads from the
// coefficient RAM, the MAC pipeline drain and an emit; with none, only the check.
// The single RAM read port sets the pace.
// Reset is synchronous; histories, phase and registers clear at once; the
// coefficient RAM has no clearing pass. A stalled output holds the emit step.
// cfg is always ready.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module polyphase_stereo_resampler (
  input  logic                                  clk,
  input  logic                                  rst,
  // configuration
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [psr_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [psr_pkg::CFG_DATA_W-1:0]        cfg_data,
  // input beats
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic                                  mode,
  input  logic [psr_pkg::IDX_W-1:0]             coef_index,
  input  logic signed [psr_pkg::COEF_W-1:0]     coef_value,
  input  logic signed [psr_pkg::SAMPLE_W-1:0]   left_in,
  input  logic signed [psr_pkg::SAMPLE_W-1:0]   right_in,
  // output beats
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic signed [psr_pkg::OUT_W-1:0]      left_out,
  output logic signed [psr_pkg::OUT_W-1:0]      right_out,
  output logic                                  last_in_run
);
  import psr_pkg::*;

  psr_state_t state;

  logic [UP_W-1:0]    up_reg;
  logic [DOWN_W-1:0]  down_reg;
  logic [PHASE_W-1:0] phase;
  logic [TAP_W-1:0]   tap;
  logic [COEF_AW-1:0] base_lo;
  logic [COEF_AW-1:0] base_hi;
  logic               last_q;
  logic               issue_v;
  logic               mul_v;

  logic signed [SAMPLE_W-1:0] left_hist  [TAPS];
  logic signed [SAMPLE_W-1:0] right_hist [TAPS];
  logic signed [SAMPLE_W-1:0] samp_l;
  logic signed [SAMPLE_W-1:0] samp_r;

  logic [BR_W-1:0]    up_eff;
  logic [PHASE_W-1:0] down_eff;
  logic [PHASE_W-1:0] phase_start;
  logic [PHASE_W-1:0] phase_next;
  logic [PHASE_W-1:0] p_full;
  logic [BR_W-1:0]    p;
  logic               has_out;

  logic               in_acc;
  logic               sample_acc;
  logic               coef_we;
  logic               rd_en;
  logic [COEF_AW-1:0] rd_addr;
  logic [COEF_W-1:0]  rd_data;
  lane_ctrl_t         lane_ctrl;
  logic               load;
  logic               slot_free;
  logic signed [ACC_W-1:0] acc_l;
  logic signed [ACC_W-1:0] acc_r;

  // Handshakes
  assign cfg_ready  = 1'b1;
  assign in_ready   = (state == ST_IDLE);
  assign in_acc     = in_valid && in_ready;
  assign sample_acc = in_acc && (mode == MODE_SAMPLE);
  assign coef_we    = in_acc && (mode == MODE_COEF) && (32'(coef_index) < 32'(COEF_DEPTH));

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      up_reg   <= UP_W'(1);
      down_reg <= DOWN_W'(1);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_UP:   up_reg   <= cfg_data[UP_W-1:0];
        REG_DOWN: down_reg <= cfg_data[DOWN_W-1:0];
        default:  ;
      endcase
    end
  end

  // Effective ratio, clamped into range
  always_comb begin
    if (up_reg == '0) begin
      up_eff = BR_W'(1);
    end else if (32'(up_reg) > 32'(MAX_UP)) begin
      up_eff = BR_W'(MAX_UP);
    end else begin
      up_eff = BR_W'(up_reg);
    end
    down_eff = (down_reg == '0) ? PHASE_W'(1) : PHASE_W'(down_reg);
  end

  // Phase step on a sample, and phase index of the next output
  assign phase_start = (phase >= down_eff) ? (down_eff - PHASE_W'(1)) : phase;
  assign phase_next  = phase_start + PHASE_W'(up_eff);
  assign has_out     = (phase >= down_eff);
  assign p_full      = phase - down_eff;
  assign p           = BR_W'(p_full);

  // Sample histories, index 0 oldest
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < TAPS; i++) begin
        left_hist[i]  <= '0;
        right_hist[i] <= '0;
      end
    end else if (sample_acc) begin
      for (int i = 0; i < TAPS - 1; i++) begin
        left_hist[i]  <= left_hist[i+1];
        right_hist[i] <= right_hist[i+1];
      end
      left_hist[TAPS-1]  <= left_in;
      right_hist[TAPS-1] <= right_in;
    end
  end

  // Coefficient address: mirrored branch for the older half, direct for newer
  always_comb begin
    if (tap <= TAP_W'(HALF_TAPS)) begin
      rd_addr = base_lo + COEF_AW'(TAP_W'(HALF_TAPS) - tap);
    end else begin
      rd_addr = base_hi + COEF_AW'(tap - TAP_W'(HALF_TAPS + 1));
    end
  end

  assign rd_en            = (state == ST_RUN);
  assign load             = (state == ST_EMIT) && slot_free;
  assign lane_ctrl.clear  = (state == ST_CHECK);
  assign lane_ctrl.mul_en = issue_v;
  assign lane_ctrl.acc_en = mul_v;

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      phase   <= '0;
      tap     <= '0;
      last_q  <= 1'b0;
      issue_v <= 1'b0;
      mul_v   <= 1'b0;
    end else begin
      issue_v <= rd_en;
      mul_v   <= issue_v;
      case (state)
        ST_IDLE: begin
          if (sample_acc) begin
            phase <= phase_next;
            state <= ST_CHECK;
          end
        end
        ST_CHECK: begin
          if (has_out) begin
            phase   <= p_full;
            base_lo <= COEF_AW'(COEF_AW'(up_eff - p) * COEF_AW'(BRANCH_LEN));
            base_hi <= COEF_AW'(COEF_AW'(p) * COEF_AW'(BRANCH_LEN));
            last_q  <= (p_full < down_eff);
            tap     <= '0;
            state   <= ST_RUN;
          end else begin
            state <= ST_IDLE;
          end
        end
        ST_RUN: begin
          if (tap == TAP_W'(TAPS - 1)) begin
            state <= ST_DRAIN;
          end else begin
            tap <= tap + TAP_W'(1);
          end
        end
        ST_DRAIN: begin
          if (!issue_v && !mul_v) begin
            state <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (slot_free) begin
            state <= last_q ? ST_IDLE : ST_CHECK;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // History taps aligned with the registered RAM read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      samp_l <= left_hist[tap];
      samp_r <= right_hist[tap];
    end
  end

  // Coefficient store
  psr_ram #(
    .WIDTH (COEF_W),
    .DEPTH (COEF_DEPTH)
  ) u_coef_ram (
    .clk   (clk),
    .we    (coef_we),
    .waddr (COEF_AW'(coef_index)),
    .wdata (coef_value),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  // Left and right MAC lanes
  psr_lane u_lane_l (
    .clk    (clk),
    .ctrl   (lane_ctrl),
    .coef   (signed'(rd_data)),
    .sample (samp_l),
    .acc    (acc_l)
  );

  psr_lane u_lane_r (
    .clk    (clk),
    .ctrl   (lane_ctrl),
    .coef   (signed'(rd_data)),
    .sample (samp_r),
    .acc    (acc_r)
  );

  // Output merge and register
  psr_merge u_merge (
    .clk         (clk),
    .rst         (rst),
    .load        (load),
    .acc_l       (acc_l),
    .acc_r       (acc_r),
    .last        (last_q),
    .slot_free   (slot_free),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .left_out    (left_out),
    .right_out   (right_out),
    .last_in_run (last_in_run)
  );

  // Checks
  `PSR_ASSERT(a_ready_quiet, in_ready |-> !issue_v && !mul_v, "input taken with MAC busy")
  `PSR_NEVER(a_addr_range, rd_en && (32'(rd_addr) >= 32'(COEF_DEPTH)), "coef read out of range")
  `PSR_ASSERT(a_sample_check, sample_acc |=> state == ST_CHECK, "sample not followed by check")
  `PSR_NEVER(a_load_blocked, load && out_valid && !out_ready, "output overwritten")

endmodule

FILE: tb/polyphase_stereo_resampler_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// polyphase_stereo_resampler_test
// Drives coefficient and stereo sample beats into the resampler and compares
// every output beat with a cycle-free predictor of the polyphase filter. A
// directed table covers saturation, rounding toward zero, ignored coefficient
// writes and register limits. Random phases with varying up/down ratios,
// backpressure and input gaps follow.
// ----------------------------------------------------------------------------
module polyphase_stereo_resampler_test;
  import psr_pkg::*;

  localparam int LIMIT      = 1000000;
  localparam int PCM_MAX    = (1 << (OUT_W - 1)) - 1;
  localparam int PCM_MIN    = -(1 << (OUT_W - 1));
  localparam int RAND_ITEMS = 30;
  localparam int QUIET_AT   = 20;

  typedef struct packed {
    logic signed [OUT_W-1:0] l;
    logic signed [OUT_W-1:0] r;
    logic                    last;
  } out_beat_t;

  typedef struct packed {
    logic                       is_cfg;
    logic [CFG_IDX_W-1:0]       reg_sel;
    logic [CFG_DATA_W-1:0]      reg_val;
    logic                       m;
    logic [IDX_W-1:0]           ci;
    logic signed [COEF_W-1:0]   cv;
    logic signed [SAMPLE_W-1:0] l;
    logic signed [SAMPLE_W-1:0] r;
    logic                       typed;
    out_beat_t                  want;
  } stim_row_t;

  // DUT ports
  logic clk = 1'b0;
  logic rst;
  logic cfg_valid;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic in_valid;
  logic in_ready;
  logic mode;
  logic [IDX_W-1:0] coef_index;
  logic signed [COEF_W-1:0] coef_value;
  logic signed [SAMPLE_W-1:0] left_in;
  logic signed [SAMPLE_W-1:0] right_in;
  logic out_valid;
  logic out_ready;
  logic signed [OUT_W-1:0] left_out;
  logic signed [OUT_W-1:0] right_out;
  logic last_in_run;

  // Predictor state
  logic signed [SAMPLE_W-1:0] left_hist [TAPS];
  logic signed [SAMPLE_W-1:0] right_hist [TAPS];
  logic signed [COEF_W-1:0]   coef_mem [COEF_DEPTH];
  logic [PHASE_W-1:0]         phase;
  logic [UP_W-1:0]            up_reg;
  logic [DOWN_W-1:0]          down_reg;

  out_beat_t pending_outputs [$];
  out_beat_t head;
  stim_row_t plan [$];
  int        fails = 0;
  int        rand_items = 0;
  int unsigned cycles = 0;
  logic      gaps_on = 1'b1;

  polyphase_stereo_resampler uut (
    .clk         (clk),
    .rst         (rst),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .mode        (mode),
    .coef_index  (coef_index),
    .coef_value  (coef_value),
    .left_in     (left_in),
    .right_in    (right_in),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .left_out    (left_out),
    .right_out   (right_out),
    .last_in_run (last_in_run)
  );

  always #5 clk = ~clk;

  // Truncate a Q30.17 sum toward zero and clip to 16 bit
  function automatic logic signed [OUT_W-1:0] to_pcm16(input logic signed [ACC_W-1:0] acc);
    logic [ACC_W-1:0] mag;
    logic signed [ACC_W-1:0] q;
    mag = acc[ACC_W-1] ? -acc : acc;
    q = mag >> FRAC_BITS;
    if (acc[ACC_W-1]) q = -q;
    if (q > PCM_MAX) q = ACC_W'(PCM_MAX);
    else if (q < PCM_MIN) q = ACC_W'(PCM_MIN);
    return q[OUT_W-1:0];
  endfunction

  // Apply one accepted input beat; queue the stereo outputs it produces
  task automatic filter_beat(input stim_row_t row, output int n);
    int unsigned up, down, p, k;
    logic signed [ACC_W-1:0] accl, accr;
    logic signed [COEF_W-1:0] c;
    out_beat_t one;
    out_beat_t run [MAX_UP];
    n = 0;
    if (row.m == MODE_COEF) begin
      // addresses past the store are dropped
      if (row.ci < COEF_DEPTH) coef_mem[row.ci] = row.cv;
    end else begin
      up = (up_reg == 0) ? 1 : (up_reg > MAX_UP) ? MAX_UP : up_reg;
      down = (down_reg == 0) ? 1 : down_reg;
      for (k = 0; k < TAPS - 1; k++) begin
        left_hist[k] = left_hist[k + 1];
        right_hist[k] = right_hist[k + 1];
      end
      left_hist[TAPS-1] = row.l;
      right_hist[TAPS-1] = row.r;
      // a shrunk down factor can leave the phase too high
      if (phase >= down) phase = PHASE_W'(down - 1);
      phase = PHASE_W'(phase + up);
      while (phase >= down) begin
        p = phase - down;
        accl = '0;
        accr = '0;
        for (k = 0; k < TAPS; k++) begin
          if (k <= HALF_TAPS) c = coef_mem[COEF_AW'((up - p) * BRANCH_LEN + HALF_TAPS - k)];
          else c = coef_mem[COEF_AW'(p * BRANCH_LEN + k - HALF_TAPS - 1)];
          accl = accl + c * left_hist[k];
          accr = accr + c * right_hist[k];
        end
        one.l = to_pcm16(accl);
        one.r = to_pcm16(accr);
        one.last = 1'b0;
        run[n] = one;
        phase = PHASE_W'(phase - down);
        n++;
      end
      for (k = 0; k < n; k++) begin
        one = run[k];
        one.last = (k == n - 1);
        pending_outputs.push_back(one);
      end
    end
  endtask

  function automatic stim_row_t coef_row(input int idx, input int val);
    stim_row_t row;
    row = '0;
    row.m = MODE_COEF;
    row.ci = idx[IDX_W-1:0];
    row.cv = val[COEF_W-1:0];
    return row;
  endfunction

  function automatic stim_row_t sample_row(input int l, input int r);
    stim_row_t row;
    row = '0;
    row.m = MODE_SAMPLE;
    row.l = l[SAMPLE_W-1:0];
    row.r = r[SAMPLE_W-1:0];
    return row;
  endfunction

  // Sample whose single output is known up front
  function automatic stim_row_t sample_row_exp(input int l, input int r, input int el,
                                               input int er);
    stim_row_t row;
    row = sample_row(l, r);
    row.typed = 1'b1;
    row.want.l = el[OUT_W-1:0];
    row.want.r = er[OUT_W-1:0];
    row.want.last = 1'b1;
    return row;
  endfunction

  function automatic stim_row_t cfg_row(input logic [CFG_IDX_W-1:0] sel, input int val);
    stim_row_t row;
    row = '0;
    row.is_cfg = 1'b1;
    row.reg_sel = sel;
    row.reg_val = val[CFG_DATA_W-1:0];
    return row;
  endfunction

  // Send one input beat; called at a falling edge, returns at one with valid high
  task automatic send_beat(input stim_row_t row);
    int n;
    if (gaps_on && $urandom_range(0, 4) == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    mode = row.m;
    coef_index = row.ci;
    coef_value = row.cv;
    left_in = row.l;
    right_in = row.r;
    in_valid = 1'b1;
    @(posedge clk);
    while (in_ready !== 1'b1) @(posedge clk);
    filter_beat(row, n);
    if (row.typed && n == 1) pending_outputs[pending_outputs.size() - 1] = row.want;
    @(negedge clk);
  endtask

  // Register write; only issued while the block is idle
  task automatic write_reg(input logic [CFG_IDX_W-1:0] sel, input logic [CFG_DATA_W-1:0] val);
    cfg_index = sel;
    cfg_data = val;
    cfg_valid = 1'b1;
    @(posedge clk);
    while (cfg_ready !== 1'b1) @(posedge clk);
    if (sel == REG_UP) up_reg = val[UP_W-1:0];
    else down_reg = val;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Hold input, let every queued output drain, then let the block sit idle
  task automatic wait_drained();
    in_valid = 1'b0;
    while (pending_outputs.size() != 0) @(posedge clk);
    repeat (8) @(negedge clk);
  endtask

  // Output side: random stall bursts
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (gaps_on && $urandom_range(0, 5) == 0) begin
        out_ready = 1'b0;
        repeat ($urandom_range(1, 4)) @(negedge clk);
      end
      out_ready = 1'b1;
    end
  end

  // Compare each output beat with the oldest expectation
  always @(posedge clk) begin
    if (!rst && out_valid === 1'b1 && out_ready) begin
      if (pending_outputs.size() == 0) begin
        $error("unexpected output beat: left_out %0d right_out %0d", left_out, right_out);
        fails++;
      end else begin
        head = pending_outputs.pop_front();
        if (left_out !== head.l) begin
          $error("left_out: expected %0d, got %0d", head.l, left_out);
          fails++;
        end
        if (right_out !== head.r) begin
          $error("right_out: expected %0d, got %0d", head.r, right_out);
          fails++;
        end
        if (last_in_run !== head.last) begin
          $error("last_in_run: expected %0d, got %0d", head.last, last_in_run);
          fails++;
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles >= LIMIT) begin
      $display("polyphase_stereo_resampler: mismatch");
      $finish;
    end
  end

  initial begin
    int i, n_items, up_pick, down_pick, idx;
    logic [CFG_DATA_W-1:0] reg_val;
    logic signed [SAMPLE_W-1:0] lv, rv;
    stim_row_t row;

    rst = 1'b1;
    cfg_valid = 1'b0;
    cfg_index = REG_UP;
    cfg_data = '0;
    in_valid = 1'b0;
    mode = MODE_COEF;
    coef_index = '0;
    coef_value = '0;
    left_in = '0;
    right_in = '0;
    for (i = 0; i < TAPS; i++) begin
      left_hist[i] = '0;
      right_hist[i] = '0;
    end
    phase = '0;
    up_reg = UP_W'(1);
    down_reg = DOWN_W'(1);

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Fill the whole store; branches 0 and 1 start at zero so the directed
    // rows below see only the newest tap
    for (i = 0; i < COEF_DEPTH; i++)
      send_beat(coef_row(i, (i < 2 * BRANCH_LEN) ? 0 : $urandom));

    // Directed rows
    plan.push_back(sample_row_exp(0, 0, 0, 0));
    plan.push_back(coef_row(7, -131072));                 // -1.0 on newest tap
    plan.push_back(sample_row_exp(8388607, -8388608, PCM_MIN, PCM_MAX));
    plan.push_back(sample_row_exp(1000, -1000, -1000, 1000));
    plan.push_back(coef_row(255, 131071));                // past the store: dropped
    plan.push_back(coef_row(COEF_DEPTH, 131071));
    plan.push_back(sample_row_exp(-1, 1, 1, -1));
    plan.push_back(coef_row(7, -65536));                  // -0.5
    plan.push_back(sample_row_exp(3, -3, -1, 1));         // rounds toward zero
    plan.push_back(cfg_row(REG_UP, 'hFE0));               // up of zero acts as 1
    plan.push_back(sample_row_exp(4, -4, -2, 2));
    plan.push_back(cfg_row(REG_DOWN, 0));                 // down of zero acts as 1
    plan.push_back(sample_row_exp(-6, 6, 3, -3));
    plan.push_back(coef_row(0, 131071));
    plan.push_back(coef_row(COEF_DEPTH - 1, 131071));
    plan.push_back(cfg_row(REG_UP, MAX_UP));              // most outputs per sample
    plan.push_back(cfg_row(REG_DOWN, 1));
    plan.push_back(sample_row(8388607, -8388608));
    plan.push_back(sample_row(-8388608, 8388607));
    plan.push_back(cfg_row(REG_UP, 31));                  // clipped to MAX_UP
    plan.push_back(sample_row(123456, -654321));
    plan.push_back(cfg_row(REG_UP, 3));
    plan.push_back(cfg_row(REG_DOWN, (1 << DOWN_W) - 1)); // phase builds, no output
    plan.push_back(sample_row(5000, -5000));
    plan.push_back(sample_row(-70000, 70000));
    plan.push_back(sample_row(32767, -32768));
    plan.push_back(cfg_row(REG_DOWN, 2));                 // phase now over the limit
    plan.push_back(sample_row(1, -1));
    plan.push_back(sample_row(-400000, 400000));

    foreach (plan[j]) begin
      if (plan[j].is_cfg) begin
        wait_drained();
        write_reg(plan[j].reg_sel, plan[j].reg_val);
      end else begin
        send_beat(plan[j]);
      end
    end

    // Random phases, each with its own ratio
    while (rand_items < RAND_ITEMS) begin
      wait_drained();
      if ($urandom_range(0, 4) == 0)
        up_pick = $urandom_range(0, 1) ? 0 : $urandom_range(MAX_UP + 1, 31);
      else
        up_pick = $urandom_range(1, MAX_UP);
      case ($urandom_range(0, 9))
        0: down_pick = 0;
        1: down_pick = (1 << DOWN_W) - 1;
        2: down_pick = $urandom_range(1, (1 << DOWN_W) - 1);
        default: down_pick = $urandom_range(1, 24);
      endcase
      reg_val = CFG_DATA_W'($urandom);
      reg_val[UP_W-1:0] = up_pick[UP_W-1:0];
      if ($urandom_range(0, 1)) begin
        write_reg(REG_UP, reg_val);
        write_reg(REG_DOWN, down_pick[DOWN_W-1:0]);
      end else begin
        write_reg(REG_DOWN, down_pick[DOWN_W-1:0]);
        write_reg(REG_UP, reg_val);
      end
      gaps_on = (rand_items < QUIET_AT) && ($urandom_range(0, 3) != 0);
      n_items = $urandom_range(4, 10);
      repeat (n_items) begin
        if ($urandom_range(0, 4) == 0) begin
          idx = ($urandom_range(0, 9) == 0) ? $urandom_range(COEF_DEPTH, 255)
                                            : $urandom_range(0, COEF_DEPTH - 1);
          row = coef_row(idx, $urandom);
        end else begin
          lv = SAMPLE_W'($urandom);
          rv = SAMPLE_W'($urandom);
          lv = lv >>> $urandom_range(0, 14);
          rv = rv >>> $urandom_range(0, 14);
          row = sample_row(lv, rv);
        end
        send_beat(row);
        rand_items++;
        // quiet tail: no gaps, no stalls
        if (rand_items >= QUIET_AT) gaps_on = 1'b0;
      end
    end

    wait_drained();
    repeat (40) @(negedge clk);
    if (fails == 0)
      $display("polyphase_stereo_resampler: match");
    else
      $display("polyphase_stereo_resampler: mismatch");
    $finish;
  end

endmodule
